// File: rtl/hvf_pkg.sv
// ----------------------------------------------------------------------------
// hvf_pkg
// Shared types and constants of the hashed visited filter.
// ----------------------------------------------------------------------------
package hvf_pkg;

    localparam int ID_W      = 32;
    localparam int OP_W      = 2;
    localparam int LEVEL_W   = 7;
    localparam int NUM_WAYS  = 4;
    localparam int WAY_W     = 2;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;
    localparam int QCNT_W      = 3;

    localparam logic [OP_W-1:0] OP_VERTEX = 2'd0;
    localparam logic [OP_W-1:0] OP_DONE   = 2'd1;
    localparam logic [OP_W-1:0] OP_START  = 2'd2;
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    typedef struct packed {
        logic [OP_W-1:0] opcode;
        logic [ID_W-1:0] vertex_id;
    } hvf_in_t;

    typedef struct packed {
        logic [ID_W-1:0] out_vertex;
        logic            is_done;
    } hvf_out_t;

    typedef struct packed {
        logic clearing;
        logic b_valid;
    } hvf_stat_t;

endpackage

// File: rtl/hvf_front.sv
// ----------------------------------------------------------------------------
// hvf_front
// Input stage: drops unused opcodes and works out the table row of each id
// (id modulo table depth) over four stages: reciprocal multiply, multiply
// back by the depth, subtract, and a final compare and subtract.
// ----------------------------------------------------------------------------
module hvf_front #(
    parameter int DEPTH = 8192
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        item_valid,
    output logic                        item_ready,
    input  hvf_pkg::hvf_in_t            item,
    output logic                        push_valid,
    output hvf_pkg::hvf_in_t            push_item,
    output logic [$clog2(DEPTH)-1:0]    push_slot,
    input  logic                        q_full
);
    import hvf_pkg::*;

    localparam int SLOT_W = $clog2(DEPTH);
    localparam int NSTG   = 4;
    localparam logic [2*ID_W-1:0] RECIP_W  = ((2*ID_W)'(1) << ID_W) / (2*ID_W)'(DEPTH);
    localparam logic [ID_W-1:0]   RECIP    = RECIP_W[ID_W-1:0];
    localparam logic [ID_W-1:0]   DEPTH_ID = ID_W'(DEPTH);
    localparam logic [SLOT_W:0]   DEPTH_V  = (SLOT_W+1)'(DEPTH);

    logic [NSTG-1:0]   stg_valid_reg;
    hvf_in_t           stg_item_reg [NSTG];
    logic [ID_W-1:0]   quot_reg;
    logic [ID_W-1:0]   prod_reg;
    logic [SLOT_W:0]   rem_reg;
    logic [SLOT_W-1:0] slot_reg;
    logic [2*ID_W-1:0] recip_prod;
    logic [ID_W-1:0]   rem_full;
    logic [SLOT_W:0]   rem_sub;
    logic [SLOT_W-1:0] slot_next;
    logic              adv;

    // quotient estimate is exact or one low, so the remainder is below 2 * DEPTH
    always_comb
    begin
        recip_prod = {{ID_W{1'b0}}, item.vertex_id} * {{ID_W{1'b0}}, RECIP};
        rem_full   = stg_item_reg[1].vertex_id - prod_reg;
        rem_sub    = rem_reg - DEPTH_V;
        slot_next  = (rem_reg >= DEPTH_V) ? rem_sub[SLOT_W-1:0] : rem_reg[SLOT_W-1:0];
    end

    assign adv        = !stg_valid_reg[NSTG-1] || !q_full;
    assign item_ready = adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stg_valid_reg <= '0;
        end
        else if (adv)
        begin
            stg_valid_reg <= {stg_valid_reg[NSTG-2:0],
                              item_valid && (item.opcode != OP_UNUSED)};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            stg_item_reg[0] <= item;
            for (int k = 1; k < NSTG; k++)
            begin
                stg_item_reg[k] <= stg_item_reg[k-1];
            end
            quot_reg <= recip_prod[2*ID_W-1:ID_W];
            prod_reg <= quot_reg * DEPTH_ID;
            rem_reg  <= rem_full[SLOT_W:0];
            slot_reg <= slot_next;
        end
    end

    assign push_valid = stg_valid_reg[NSTG-1];
    assign push_item  = stg_item_reg[NSTG-1];
    assign push_slot  = slot_reg;

endmodule

// File: rtl/hvf_queue.sv
// ----------------------------------------------------------------------------
// hvf_queue
// Short FIFO between the front and the table back end.
// ----------------------------------------------------------------------------
module hvf_queue #(
    parameter int SLOT_W = 13
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push_valid,
    input  hvf_pkg::hvf_in_t    push_item,
    input  logic [SLOT_W-1:0]   push_slot,
    output logic                q_full,
    output logic                q_valid,
    output hvf_pkg::hvf_in_t    q_item,
    output logic [SLOT_W-1:0]   q_slot,
    input  logic                q_pop
);
    import hvf_pkg::*;

    hvf_in_t           item_mem [QUEUE_DEPTH];
    logic [SLOT_W-1:0] slot_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] head_reg, head_next;
    logic [QPTR_W-1:0] tail_reg, tail_next;
    logic [QCNT_W-1:0] cnt_reg,  cnt_next;
    logic              push;

    assign q_full  = (cnt_reg == QCNT_W'(QUEUE_DEPTH));
    assign q_valid = (cnt_reg != '0);
    assign push    = push_valid && !q_full;
    assign q_item  = item_mem[head_reg];
    assign q_slot  = slot_mem[head_reg];

    always_comb
    begin
        head_next = q_pop ? head_reg + 1'b1 : head_reg;
        tail_next = push  ? tail_reg + 1'b1 : tail_reg;
        cnt_next  = cnt_reg + QCNT_W'(push) - QCNT_W'(q_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg <= '0;
            tail_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            head_reg <= head_next;
            tail_reg <= tail_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            item_mem[tail_reg] <= push_item;
            slot_mem[tail_reg] <= push_slot;
        end
    end

endmodule

// File: rtl/hvf_back.sv
// ----------------------------------------------------------------------------
// hvf_back
// Four-way seen tables: lookup, round-robin insert, table clearing pass,
// level register and result register.
// ----------------------------------------------------------------------------
module hvf_back #(
    parameter int DEPTH = 8192
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_valid,
    input  logic [hvf_pkg::LEVEL_W-1:0]     cfg_data,
    input  logic                            q_valid,
    input  hvf_pkg::hvf_in_t                q_item,
    input  logic [$clog2(DEPTH)-1:0]        q_slot,
    output logic                            q_pop,
    output logic                            result_valid,
    input  logic                            result_ready,
    output hvf_pkg::hvf_out_t               result,
    output hvf_pkg::hvf_stat_t              stat
);
    import hvf_pkg::*;

    localparam int SLOT_W = $clog2(DEPTH);
    localparam logic [SLOT_W-1:0] LAST_ROW = SLOT_W'(DEPTH - 1);

    logic [LEVEL_W-1:0] level_reg;
    logic [WAY_W-1:0]   victim_reg, victim_next;
    logic               clearing_reg, clearing_next;
    logic [SLOT_W-1:0]  clr_cnt_reg, clr_cnt_next;
    logic               b_valid_reg, b_valid_next;
    hvf_in_t            b_item_reg;
    logic [SLOT_W-1:0]  b_slot_reg;
    logic               fwd_valid_reg, fwd_valid_next;
    logic [WAY_W-1:0]   fwd_way_reg;
    logic [SLOT_W-1:0]  fwd_slot_reg;
    logic [ID_W-1:0]    fwd_id_reg;
    logic               result_valid_reg, result_valid_next;
    hvf_out_t           result_reg;

    logic [ID_W-1:0]     rd_q [NUM_WAYS];
    logic [ID_W-1:0]     cur  [NUM_WAYS];
    logic [NUM_WAYS-1:0] hit_vec;
    logic [NUM_WAYS-1:0] wr_en;
    logic [SLOT_W-1:0]   wr_addr;
    logic [ID_W-1:0]     wr_data;
    logic                hit, out_free, fire, emit, b_fire, b_emit;
    logic                item_wr, start_fire, clear_req, hold_start, load;

    always_comb
    begin
        for (int w = 0; w < NUM_WAYS; w++)
        begin
            cur[w] = rd_q[w];
            if (fwd_valid_reg && fwd_way_reg == WAY_W'(w) && fwd_slot_reg == b_slot_reg)
            begin
                cur[w] = fwd_id_reg;
            end
            hit_vec[w] = (cur[w] == b_item_reg.vertex_id);
        end
    end

    assign hit      = |hit_vec;
    assign out_free = !result_valid_reg || result_ready;

    always_comb
    begin
        fire = 1'b0;
        emit = 1'b0;
        case (b_item_reg.opcode)
            OP_VERTEX:
            begin
                emit = !hit;
                fire = hit || out_free;
            end
            OP_DONE:
            begin
                emit = 1'b1;
                fire = out_free;
            end
            default:
            begin
                fire = 1'b1;
            end
        endcase
    end

    assign b_fire     = b_valid_reg && fire;
    assign b_emit     = b_fire && emit;
    assign item_wr    = b_fire && (b_item_reg.opcode == OP_VERTEX) && !hit;
    assign start_fire = b_fire && (b_item_reg.opcode == OP_START);
    assign clear_req  = start_fire && (level_reg == '0);
    assign hold_start = b_valid_reg && (b_item_reg.opcode == OP_START) && (level_reg == '0);
    assign load       = q_valid && !clearing_reg && !hold_start && (!b_valid_reg || b_fire);
    assign q_pop      = load;

    // table write port: clearing pass or insert
    always_comb
    begin
        if (clearing_reg)
        begin
            wr_en   = '1;
            wr_addr = clr_cnt_reg;
            wr_data = '0;
        end
        else
        begin
            for (int w = 0; w < NUM_WAYS; w++)
            begin
                wr_en[w] = item_wr && (victim_reg == WAY_W'(w));
            end
            wr_addr = b_slot_reg;
            wr_data = b_item_reg.vertex_id;
        end
    end

    genvar g;
    generate
        for (g = 0; g < NUM_WAYS; g++)
        begin : g_way
            logic [ID_W-1:0] way_mem [DEPTH];
            always_ff @(posedge clk)
            begin
                if (wr_en[g])
                begin
                    way_mem[wr_addr] <= wr_data;
                end
                if (load)
                begin
                    rd_q[g] <= way_mem[q_slot];
                end
            end
        end
    endgenerate

    always_comb
    begin
        victim_next = victim_reg;
        if (start_fire)
        begin
            victim_next = '0;
        end
        else if (item_wr)
        begin
            victim_next = victim_reg + 1'b1;
        end

        clearing_next = clearing_reg;
        clr_cnt_next  = clr_cnt_reg;
        if (clearing_reg)
        begin
            if (clr_cnt_reg == LAST_ROW)
            begin
                clearing_next = 1'b0;
                clr_cnt_next  = '0;
            end
            else
            begin
                clr_cnt_next = clr_cnt_reg + 1'b1;
            end
        end
        else if (clear_req)
        begin
            clearing_next = 1'b1;
            clr_cnt_next  = '0;
        end

        b_valid_next = b_valid_reg;
        if (load)
        begin
            b_valid_next = 1'b1;
        end
        else if (b_fire)
        begin
            b_valid_next = 1'b0;
        end

        // write made at the same edge as the read is not seen by the read
        fwd_valid_next = load ? item_wr : fwd_valid_reg;

        result_valid_next = result_valid_reg;
        if (b_emit)
        begin
            result_valid_next = 1'b1;
        end
        else if (result_ready)
        begin
            result_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_reg        <= '0;
            victim_reg       <= '0;
            clearing_reg     <= 1'b1;
            clr_cnt_reg      <= '0;
            b_valid_reg      <= 1'b0;
            fwd_valid_reg    <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                level_reg <= cfg_data;
            end
            victim_reg       <= victim_next;
            clearing_reg     <= clearing_next;
            clr_cnt_reg      <= clr_cnt_next;
            b_valid_reg      <= b_valid_next;
            fwd_valid_reg    <= fwd_valid_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            b_item_reg   <= q_item;
            b_slot_reg   <= q_slot;
            fwd_way_reg  <= victim_reg;
            fwd_slot_reg <= b_slot_reg;
            fwd_id_reg   <= b_item_reg.vertex_id;
        end
        if (b_emit)
        begin
            result_reg.is_done    <= (b_item_reg.opcode == OP_DONE);
            result_reg.out_vertex <= (b_item_reg.opcode == OP_DONE) ?
                                     '0 : b_item_reg.vertex_id;
        end
    end

    assign result_valid  = result_valid_reg;
    assign result        = result_reg;
    assign stat.clearing = clearing_reg;
    assign stat.b_valid  = b_valid_reg;

endmodule

// File: rtl/hashed_visited_filter_core.sv
// ----------------------------------------------------------------------------
// hashed_visited_filter_core
// Duplicate filter for BFS neighbour ids, four direct-mapped seen tables.
//
// Input channel item_valid/item_ready/item carries an opcode and a vertex id.
// Vertex items not found in any way at row (id mod TABLE_DEPTH) are inserted
// round-robin and passed on; found ones are dropped. End-of-level items give
// a marker result, start items reset the way pointer and, at level zero,
// clear the tables. Level is written on cfg_valid/cfg_ready/cfg_data.
// Throughput: one item per cycle, while result_ready is high and no clearing
// pass runs. Path from input to result: four row-computation stages, queue,
// table read, result register. Output is registered; while result_ready is
// low the back end holds and the four-entry queue and front pipeline fill
// before item_ready drops. After reset, and after each start item at level
// zero, the tables are swept one row per cycle; meanwhile no items reach them.
// ----------------------------------------------------------------------------
module hashed_visited_filter_core #(
    parameter int TABLE_DEPTH = 8192
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            item_valid,
    output logic                            item_ready,
    input  hvf_pkg::hvf_in_t                item,
    output logic                            result_valid,
    input  logic                            result_ready,
    output hvf_pkg::hvf_out_t               result,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [hvf_pkg::LEVEL_W-1:0]     cfg_data
);
    import hvf_pkg::*;

    localparam int SLOT_W = $clog2(TABLE_DEPTH);

    logic              push_valid;
    hvf_in_t           push_item;
    logic [SLOT_W-1:0] push_slot;
    logic              q_full;
    logic              q_valid;
    hvf_in_t           q_item;
    logic [SLOT_W-1:0] q_slot;
    logic              q_pop;
    hvf_stat_t         stat;

    assign cfg_ready = 1'b1;

    hvf_front #(.DEPTH(TABLE_DEPTH)) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item),
        .push_valid (push_valid),
        .push_item  (push_item),
        .push_slot  (push_slot),
        .q_full     (q_full)
    );

    hvf_queue #(.SLOT_W(SLOT_W)) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_item  (push_item),
        .push_slot  (push_slot),
        .q_full     (q_full),
        .q_valid    (q_valid),
        .q_item     (q_item),
        .q_slot     (q_slot),
        .q_pop      (q_pop)
    );

    hvf_back #(.DEPTH(TABLE_DEPTH)) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_data     (cfg_data),
        .q_valid      (q_valid),
        .q_item       (q_item),
        .q_slot       (q_slot),
        .q_pop        (q_pop),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .stat         (stat)
    );

    a_pop_when_ready: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> (q_valid && !stat.clearing))
        else $error("queue popped while empty or clearing");

    a_clear_empty_back: assert property (@(posedge clk) disable iff (!rst_n)
        stat.clearing |-> !stat.b_valid)
        else $error("item held in back end during clearing pass");

    a_clear_start_no_pop: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(stat.clearing) |-> !$past(q_pop))
        else $error("item loaded as clearing pass began");

    a_marker_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.is_done) |-> (result.out_vertex == '0))
        else $error("end marker carries a vertex id");

endmodule

// File: tb/hashed_visited_filter_core_test.sv
// ----------------------------------------------------------------------------
// hashed_visited_filter_core_test
// Self-checking bench for the four-way hashed visited filter. A clocked driver
// feeds items from a queue with random gaps. A receiver stalls at random.
// Accepted items run through a behavioural copy of the seen tables and the
// round-robin way pointer, and each result is checked in order against it.
// Directed items cover the corner cases. Random phases then step the level
// register through zero, one, 127 and random values, using ids crowded onto
// a few rows so that hits, misses and evictions all occur often.
// ----------------------------------------------------------------------------
module hashed_visited_filter_core_test;

    timeunit 1ns;
    timeprecision 1ps;

    import hvf_pkg::*;

    localparam int TABLE_DEPTH = 8192;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int NUM_PHASES  = 10;
    localparam int PHASE_ITEMS = 48;

    logic                clk;
    logic                rst_n        = 1'b0;
    logic                item_valid   = 1'b0;
    logic                item_ready;
    hvf_in_t             item         = '0;
    logic                result_valid;
    logic                result_ready = 1'b0;
    hvf_out_t            result;
    logic                cfg_valid    = 1'b0;
    logic                cfg_ready;
    logic [LEVEL_W-1:0]  cfg_data     = '0;

    hvf_in_t             bfs_items_q[$];
    hvf_out_t            forwarded_q[$];
    logic [ID_W-1:0]     recent_ids[$];
    logic [ID_W-1:0]     hi_tags[8];

    logic [ID_W-1:0]     seen_tbl[NUM_WAYS][TABLE_DEPTH];
    logic [WAY_W-1:0]    next_way  = '0;
    logic [LEVEL_W-1:0]  level_reg = '0;

    logic                item_fire = 1'b0;
    logic                out_fire  = 1'b0;
    bit                  no_idle   = 1'b0;
    int                  send_gap  = 0;
    int                  hold_cycles = 0;
    int                  mismatch_cnt = 0;
    int                  cycle_cnt = 0;

    hashed_visited_filter_core #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    task automatic clear_seen();
        for (int w = 0; w < NUM_WAYS; w++)
        begin
            for (int r = 0; r < TABLE_DEPTH; r++)
                seen_tbl[w][r] = '0;
        end
    endtask

    // behavioural filter: updates tables and queues the result it causes
    task automatic filter_item(input hvf_in_t it);
        int       slot;
        bit       hit;
        hvf_out_t res;
        case (it.opcode)
            OP_START:
            begin
                next_way = '0;
                if (level_reg == '0)
                    clear_seen();
            end
            OP_DONE:
            begin
                res.out_vertex = '0;
                res.is_done    = 1'b1;
                forwarded_q.push_back(res);
            end
            OP_VERTEX:
            begin
                slot = int'(it.vertex_id % TABLE_DEPTH);
                hit  = 1'b0;
                for (int w = 0; w < NUM_WAYS; w++)
                begin
                    if (seen_tbl[w][slot] == it.vertex_id)
                        hit = 1'b1;
                end
                if (!hit)
                begin
                    seen_tbl[next_way][slot] = it.vertex_id;
                    next_way = next_way + 1'b1;
                    res.out_vertex = it.vertex_id;
                    res.is_done    = 1'b0;
                    forwarded_q.push_back(res);
                end
            end
            default: ;
        endcase
    endtask

    // item driver
    always @(negedge clk)
    begin
        if (item_valid && !item_fire)
        begin
        end
        else if (send_gap > 0)
        begin
            item_valid <= 1'b0;
            send_gap--;
        end
        else if (bfs_items_q.size() > 0)
        begin
            item       <= bfs_items_q.pop_front();
            item_valid <= 1'b1;
            send_gap   = no_idle ? 0 : $urandom_range(0, 8);
        end
        else
            item_valid <= 1'b0;
    end

    // result receiver
    always @(negedge clk)
    begin
        if (out_fire)
            hold_cycles = no_idle ? 0 : $urandom_range(0, 8);
        if (hold_cycles > 0)
        begin
            result_ready <= 1'b0;
            hold_cycles--;
        end
        else
            result_ready <= 1'b1;
    end

    // monitor and checker
    always @(posedge clk)
    begin
        item_fire <= rst_n && item_valid && item_ready;
        out_fire  <= rst_n && result_valid && result_ready;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
                level_reg = cfg_data;
            if (item_valid && item_ready)
                filter_item(item);
            if (result_valid && result_ready)
            begin
                if (forwarded_q.size() == 0)
                begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10)
                        $display("unexpected result: id=%h done=%b",
                                 result.out_vertex, result.is_done);
                end
                else
                begin
                    hvf_out_t exp_res;
                    exp_res = forwarded_q.pop_front();
                    if (result.out_vertex !== exp_res.out_vertex ||
                        result.is_done !== exp_res.is_done)
                    begin
                        mismatch_cnt++;
                        if (mismatch_cnt <= 10)
                            $display("result mismatch: expected id=%h done=%b, got id=%h done=%b",
                                     exp_res.out_vertex, exp_res.is_done,
                                     result.out_vertex, result.is_done);
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_cnt);
            $display("Simulation FAILED");
            $finish;
        end
    end

    task automatic queue_item(input logic [OP_W-1:0] op, input logic [ID_W-1:0] id);
        hvf_in_t it;
        it.opcode    = op;
        it.vertex_id = id;
        bfs_items_q.push_back(it);
    endtask

    // wait until every item is in and every result out, then let the pipe drain
    task automatic settle();
        while (bfs_items_q.size() != 0 || item_valid || forwarded_q.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_level(input logic [LEVEL_W-1:0] lvl);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= lvl;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // ids crowded onto a few rows, recent repeats, and fully random ones
    function automatic logic [ID_W-1:0] pick_vertex_id();
        int              sel;
        logic [ID_W-1:0] id;
        sel = $urandom_range(0, 99);
        if (sel < 30 && recent_ids.size() > 0)
            id = recent_ids[$urandom_range(0, recent_ids.size() - 1)];
        else if (sel < 80)
            id = hi_tags[$urandom_range(0, 7)] * TABLE_DEPTH + $urandom_range(0, 15);
        else
            id = $urandom;
        recent_ids.push_back(id);
        if (recent_ids.size() > 32)
            void'(recent_ids.pop_front());
        return id;
    endfunction

    initial
    begin
        int                 ph;
        int                 sel;
        int                 clears_left;
        logic [LEVEL_W-1:0] lvl;

        clear_seen();
        hi_tags[0] = '0;
        hi_tags[1] = 32'hFFFF_FFFF / TABLE_DEPTH;
        for (int k = 2; k < 8; k++)
            hi_tags[k] = $urandom_range(0, 32'hFFFF_FFFF / TABLE_DEPTH);
        clears_left = 8;

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: level zero, zero-filled tables, row eviction, clearing start
        write_level('0);
        queue_item(OP_VERTEX, 32'h0000_0000);
        queue_item(OP_VERTEX, 32'hFFFF_FFFF);
        queue_item(OP_VERTEX, 32'hFFFF_FFFF);
        queue_item(OP_DONE,   32'hFFFF_FFFF);
        queue_item(OP_UNUSED, 32'h0000_0005);
        queue_item(OP_VERTEX, 32'h0000_0005);
        for (int k = 0; k < 5; k++)
            queue_item(OP_VERTEX, 32'd7 + k * TABLE_DEPTH);
        queue_item(OP_VERTEX, 32'd7);
        queue_item(OP_START,  32'hFFFF_FFFF);
        queue_item(OP_VERTEX, 32'hFFFF_FFFF);
        queue_item(OP_VERTEX, 32'h8000_0000);
        queue_item(OP_DONE,   32'h0000_0000);

        // directed: start at top level keeps the tables
        settle();
        write_level('1);
        queue_item(OP_START,  32'h0000_0000);
        queue_item(OP_VERTEX, 32'hFFFF_FFFF);
        queue_item(OP_VERTEX, 32'h0000_0000);
        queue_item(OP_VERTEX, 32'h8000_0000);
        queue_item(OP_VERTEX, 32'h0000_0001);
        queue_item(OP_DONE,   32'h5555_AAAA);

        for (ph = 0; ph < NUM_PHASES; ph++)
        begin
            settle();
            if (ph % 3 == 0)
                lvl = '0;
            else if (ph == 1)
                lvl = '1;
            else if (ph == 2)
                lvl = 7'd1;
            else
                lvl = $urandom_range(1, 127);
            no_idle = (ph % 4 == 2);
            write_level(lvl);
            if (ph != 5)
                queue_item(OP_START, $urandom);
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                sel = $urandom_range(0, 99);
                if (sel < 78)
                    queue_item(OP_VERTEX, pick_vertex_id());
                else if (sel < 88)
                    queue_item(OP_DONE, $urandom);
                else if (sel < 94)
                    queue_item(OP_UNUSED, $urandom);
                else if (lvl != '0)
                    queue_item(OP_START, $urandom);
                else if (clears_left > 0)
                begin
                    clears_left--;
                    queue_item(OP_START, $urandom);
                end
                else
                    queue_item(OP_DONE, $urandom);
            end
            queue_item(OP_DONE, $urandom);
        end

        while (bfs_items_q.size() != 0 || item_valid || forwarded_q.size() != 0)
            @(posedge clk);
        repeat (32) @(posedge clk);

        if (forwarded_q.size() != 0)
            $display("%0d expected results never arrived", forwarded_q.size());
        if (mismatch_cnt == 0 && forwarded_q.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
